// ===== hdl/embs_pkg.sv =====
`default_nettype none

package embs_pkg;

  // Row size and derived widths
  localparam int NUM_BUCKETS = 64;
  localparam int CNT_W       = $clog2(NUM_BUCKETS + 1);
  localparam int IDX_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  localparam int LVL_W      = 16;
  localparam int CFG_W      = 16;
  localparam int ARR_W      = 16;
  localparam int DROP_W     = 16;
  localparam int SENT_W     = LVL_W + CNT_W;
  localparam int SENT_OUT_W = 22;
  localparam int ACT_OUT_W  = 7;
  localparam int SENT_EXT_W = (SENT_W > SENT_OUT_W) ? SENT_W : SENT_OUT_W;
  localparam int ACT_EXT_W  = (CNT_W > ACT_OUT_W) ? CNT_W : ACT_OUT_W;

  localparam logic [SENT_OUT_W-1:0] SENT_MAX = '1;
  localparam logic [ACT_OUT_W-1:0]  ACT_MAX  = '1;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_RATE = 1'b1;

  localparam logic [CFG_W-1:0] CAPACITY_RESET   = 16'd16;
  localparam logic [CFG_W-1:0] DRAIN_RATE_RESET = 16'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_OPEN,
    ST_DRAIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic fill;
    logic rewind;
    logic open;
    logic drain;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_done;
    logic open_done;
    logic drain_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/elastic_multi_bucket_shaper_unit.sv =====
`default_nettype none

// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+------------------------------------------
// s_*      | in  | s_tvalid_i/s_tready_o| tdata[15:0] arrivals
// m_*      | out | m_tvalid_o/m_tready_i| tdata[21:0] sent, [28:22] active_buckets,
//          |     |                      | [44:29] dropped, [47:45] zero
// cfg_*    | in  | cfg_we_i             | cfg_idx_i selects register, cfg_wdata_i
//
// Each request runs a fill pass over the F open buckets, opens O new ones, then drains
// the D buckets that are open (D <= F + O), reading each through the level RAM, which
// gives one read and one write per cycle.
// Reset clears the active count to one and marks every bucket level as zero.
// A new request is taken while the previous result still waits in the output
// register; that result holds the next request at its final load until m_tready_i.

module elastic_multi_bucket_shaper_unit
  import embs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_tvalid_i,
  output logic                        s_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata_i,   // [15:0] arrivals
  output logic                        m_tvalid_o,
  input  wire logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_tdata_o,   // sent, active_buckets, dropped, pad
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i
);

  logic [CFG_W-1:0]      capacity_q, capacity_d;
  logic [CFG_W-1:0]      drain_rate_q, drain_rate_d;
  dp_cmd_t               cmd;
  dp_sts_t               sts;
  logic [SENT_OUT_W-1:0] sent;
  logic [ACT_OUT_W-1:0]  active;
  logic [DROP_W-1:0]     dropped;

  // Configuration writes land at once; the user must write only while idle, unchecked
  always_comb begin
    capacity_d   = capacity_q;
    drain_rate_d = drain_rate_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAPACITY:   capacity_d   = cfg_wdata_i;
        CFG_DRAIN_RATE: drain_rate_d = cfg_wdata_i;
        default: begin
          capacity_d = capacity_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q   <= CAPACITY_RESET;
      drain_rate_q <= DRAIN_RATE_RESET;
    end else begin
      capacity_q   <= capacity_d;
      drain_rate_q <= drain_rate_d;
    end
  end

  // Sequence the fill, open and drain passes
  embs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_tvalid_i),
    .req_ready_o (s_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Bucket levels, running totals and the result register
  embs_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .arrivals_i   (s_tdata_i[ARR_W-1:0]),
    .capacity_i   (capacity_q),
    .drain_rate_i (drain_rate_q),
    .out_ready_i  (m_tready_i),
    .out_valid_o  (m_tvalid_o),
    .sent_o       (sent),
    .active_o     (active),
    .dropped_o    (dropped)
  );

  // Pack result fields from the lowest bit up, pad to whole bytes
  assign m_tdata_o = {
    {(OUT_TDATA_W - SENT_OUT_W - ACT_OUT_W - DROP_W){1'b0}},
    dropped,
    active,
    sent
  };

endmodule

`default_nettype wire

// ===== hdl/embs_ram.sv =====
`default_nettype none

module embs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/embs_ctrl.sv =====
`default_nettype none

module embs_ctrl
  import embs_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    req_valid_i,
  output logic         req_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_done) begin
          cmd_o.rewind = 1'b1;
          state_d      = ST_OPEN;
        end
      end
      ST_OPEN: begin
        cmd_o.open = 1'b1;
        if (sts_i.open_done) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.drain = 1'b1;
        if (sts_i.drain_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/embs_dpath.sv =====
`default_nettype none

module embs_dpath
  import embs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dp_cmd_t               cmd_i,
  output dp_sts_t                    sts_o,
  input  wire logic [ARR_W-1:0]      arrivals_i,
  input  wire logic [CFG_W-1:0]      capacity_i,
  input  wire logic [CFG_W-1:0]      drain_rate_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [SENT_OUT_W-1:0]      sent_o,
  output logic [ACT_OUT_W-1:0]       active_o,
  output logic [DROP_W-1:0]          dropped_o
);

  logic [ARR_W-1:0]       left_q, left_d;
  logic [SENT_W-1:0]      sent_q, sent_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]       ridx_q;
  logic                   rvalid_q;
  logic [NUM_BUCKETS-1:0] valid_q;

  logic                   out_valid_q, out_valid_d;
  logic [SENT_OUT_W-1:0]  out_sent_q;
  logic [ACT_OUT_W-1:0]   out_active_q;
  logic [DROP_W-1:0]      out_dropped_q;

  logic                   issue;
  logic                   live;
  logic                   open_done;
  logic [LVL_W-1:0]       rdata;
  logic [LVL_W-1:0]       level;
  logic [LVL_W-1:0]       room;
  logic [LVL_W-1:0]       take_fill;
  logic [LVL_W-1:0]       take_open;
  logic [LVL_W-1:0]       give;
  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [LVL_W-1:0]       wdata;
  logic [SENT_EXT_W-1:0]  sent_ext;
  logic [ACT_EXT_W-1:0]   act_ext;
  logic [SENT_OUT_W-1:0]  sent_sat;
  logic [ACT_OUT_W-1:0]   act_sat;

  embs_ram #(
    .WIDTH (LVL_W),
    .DEPTH (NUM_BUCKETS)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // Read one bucket per cycle; the bucket read last cycle is updated now
  assign issue     = (cmd_i.fill || cmd_i.drain) && (rd_idx_q < count_q);
  assign live      = rvalid_q && (ridx_q < count_q);
  assign level     = valid_q[ridx_q[IDX_W-1:0]] ? rdata : '0;
  assign room      = (level < capacity_i) ? (capacity_i - level) : '0;
  assign take_fill = (left_q < room) ? left_q : room;
  assign take_open = (left_q < capacity_i) ? left_q : capacity_i;
  assign give      = (level < drain_rate_i) ? level : drain_rate_i;
  assign open_done = (left_q == '0) || (count_q == CNT_W'(NUM_BUCKETS));

  assign sts_o.fill_done  = (rd_idx_q >= count_q) && !rvalid_q;
  assign sts_o.drain_done = (rd_idx_q >= count_q) && !rvalid_q;
  assign sts_o.open_done  = open_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    we       = 1'b0;
    waddr    = ridx_q[IDX_W-1:0];
    wdata    = level;
    left_d   = left_q;
    count_d  = count_q;
    sent_d   = sent_q;
    rd_idx_d = issue ? (rd_idx_q + CNT_W'(1)) : rd_idx_q;
    if (cmd_i.start) begin
      left_d   = arrivals_i;
      sent_d   = '0;
      rd_idx_d = '0;
    end
    if (cmd_i.rewind) begin
      rd_idx_d = '0;
    end
    if (cmd_i.fill && live) begin
      we     = 1'b1;
      wdata  = level + take_fill;
      left_d = left_q - take_fill;
    end
    if (cmd_i.open && !open_done) begin
      we      = 1'b1;
      waddr   = count_q[IDX_W-1:0];
      wdata   = take_open;
      left_d  = left_q - take_open;
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.drain && live) begin
      if (level == '0) begin
        // first empty bucket closes the tail
        count_d = ridx_q;
      end else begin
        we     = 1'b1;
        wdata  = level - give;
        sent_d = sent_q + SENT_W'(give);
      end
    end
  end

  assign sent_ext = SENT_EXT_W'(sent_q);
  assign act_ext  = ACT_EXT_W'(count_q);
  assign sent_sat = (sent_ext > SENT_EXT_W'(SENT_MAX)) ? SENT_MAX
                                                       : sent_ext[SENT_OUT_W-1:0];
  assign act_sat  = (act_ext > ACT_EXT_W'(ACT_MAX)) ? ACT_MAX : act_ext[ACT_OUT_W-1:0];

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CNT_W'(1);
      rd_idx_q    <= '0;
      rvalid_q    <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      rvalid_q    <= issue;
      out_valid_q <= out_valid_d;
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    sent_q <= sent_d;
    ridx_q <= rd_idx_q;
    if (cmd_i.load_out) begin
      out_sent_q    <= sent_sat;
      out_active_q  <= act_sat;
      out_dropped_q <= left_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sent_o      = out_sent_q;
  assign active_o    = out_active_q;
  assign dropped_o   = out_dropped_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(NUM_BUCKETS))
    else $error("active count beyond row size");

  a_open_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.open && !open_done |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("opening a bucket did not advance the count");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill && live |-> (wdata <= capacity_i) || (wdata == level))
    else $error("fill pushed a bucket above capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !out_valid_q || out_ready_i)
    else $error("result register overwritten before taken");
`endif

endmodule

`default_nettype wire

// ===== tb/embs_checker.sv =====
`timescale 1ns / 100ps

module embs_checker
  import embs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_tvalid_i,
  input  wire logic                   s_tready_i,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata_i,   // [15:0] arrivals
  input  wire logic                   m_tvalid_i,
  input  wire logic                   m_tready_i,
  input  wire logic [OUT_TDATA_W-1:0] m_tdata_i,   // sent, active_buckets, dropped, pad
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i,
  output int                          pending_o,
  output int                          fail_count_o
);

  localparam int ACT_LSB  = SENT_OUT_W;
  localparam int DROP_LSB = SENT_OUT_W + ACT_OUT_W;
  localparam int PAD_LSB  = DROP_LSB + DROP_W;

  typedef struct packed {
    logic [SENT_OUT_W-1:0] sent;
    logic [ACT_OUT_W-1:0]  active;
    logic [DROP_W-1:0]     dropped;
  } tick_result_t;

  logic [LVL_W-1:0] level_q [NUM_BUCKETS];
  int unsigned      open_count;
  int unsigned      capacity_q;
  int unsigned      drain_rate_q;
  tick_result_t     tick_results_q [$];
  int               mismatches;

  // One tick: top up the open buckets, open new ones, then drain in order.
  function automatic tick_result_t shape_tick(input logic [ARR_W-1:0] arrivals);
    int unsigned  left;
    int unsigned  room;
    int unsigned  take;
    int unsigned  sent;
    int unsigned  n;
    tick_result_t res;
    left = arrivals;
    sent = 0;
    for (int k = 0; k < open_count; k++) begin
      room = (level_q[k] < capacity_q) ? capacity_q - level_q[k] : 0;
      take = (left < room) ? left : room;
      level_q[k] = LVL_W'(level_q[k] + take);
      left -= take;
    end
    while (left > 0 && open_count < NUM_BUCKETS) begin
      take = (left < capacity_q) ? left : capacity_q;
      level_q[open_count] = LVL_W'(take);
      open_count++;
      left -= take;
    end
    n = open_count;
    for (int k = 0; k < n; k++) begin
      if (level_q[k] == '0) begin
        open_count = k;
        break;
      end
      take = (level_q[k] < drain_rate_q) ? level_q[k] : drain_rate_q;
      level_q[k] = LVL_W'(level_q[k] - take);
      sent += take;
    end
    res.sent    = (sent > SENT_MAX) ? SENT_MAX : SENT_OUT_W'(sent);
    res.active  = (open_count > ACT_MAX) ? ACT_MAX : ACT_OUT_W'(open_count);
    res.dropped = DROP_W'(left);
    return res;
  endfunction

  task automatic flag(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t checker: %s", $realtime, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t want;
    tick_result_t got;
    logic [OUT_TDATA_W-PAD_LSB-1:0] pad;
    if (!rst_ni) begin
      foreach (level_q[k]) level_q[k] = '0;
      open_count   = 1;
      capacity_q   = CAPACITY_RESET;
      drain_rate_q = DRAIN_RATE_RESET;
      tick_results_q.delete();
      mismatches   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CAPACITY:   capacity_q   = cfg_wdata_i;
          CFG_DRAIN_RATE: drain_rate_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got.sent    = m_tdata_i[SENT_OUT_W-1:0];
        got.active  = m_tdata_i[ACT_LSB +: ACT_OUT_W];
        got.dropped = m_tdata_i[DROP_LSB +: DROP_W];
        pad         = m_tdata_i[OUT_TDATA_W-1:PAD_LSB];
        if (tick_results_q.size() == 0) begin
          flag($sformatf("result with no request outstanding: sent=%0d active=%0d dropped=%0d",
                         got.sent, got.active, got.dropped));
        end else begin
          want = tick_results_q.pop_front();
          if (got != want || pad != '0) begin
            flag($sformatf("expected sent=%0d active=%0d dropped=%0d pad=0, got sent=%0d active=%0d dropped=%0d pad=%0h",
                           want.sent, want.active, want.dropped,
                           got.sent, got.active, got.dropped, pad));
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        tick_results_q.push_back(shape_tick(s_tdata_i[ARR_W-1:0]));
      end
      pending_o    <= tick_results_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import embs_pkg::*;

  // Longest stretch with no handshake on either side: a full-row request, a long
  // receiver stall and a long sender gap, taken many times over.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_SETTLE     = 300;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_TICKS    = 112;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;      // [15:0] arrivals
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;           // [21:0] sent, [28:22] active, [44:29] dropped
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = CFG_CAPACITY;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  int          pending;
  int          fail_count;
  int          quiet_cycles;
  int unsigned cur_cap  = CAPACITY_RESET;
  int unsigned cur_rate = DRAIN_RATE_RESET;
  int          burst_left = 0;

  always #10 clk = ~clk;

  elastic_multi_bucket_shaper_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  embs_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Receiver: switch between long windows that are always ready, lightly
  // stalled or heavily stalled, so stalls land on every phase of a request.
  int rx_stall_left;
  int rx_mode_left;
  int rx_mode;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_tready      <= 1'b0;
      rx_stall_left <= 0;
      rx_mode_left  <= 0;
      rx_mode       <= 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode_left <= $urandom_range(200, 2000);
        rx_mode      <= $urandom_range(0, 2);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      if (rx_stall_left != 0) begin
        m_tready      <= 1'b0;
        rx_stall_left <= rx_stall_left - 1;
      end else if (rx_mode == 1 && $urandom_range(0, 3) == 0) begin
        m_tready      <= 1'b0;
        rx_stall_left <= $urandom_range(0, 3);
      end else if (rx_mode == 2 && $urandom_range(0, 2) == 0) begin
        m_tready      <= 1'b0;
        rx_stall_left <= $urandom_range(0, 40);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run once nothing moves on either channel for too long.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one tick and hold it until accepted; close a burst with a random gap.
  task automatic send_tick(input int unsigned arrivals);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(arrivals);
    do @(posedge clk); while (!s_tready);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 250) : $urandom_range(0, 24);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every outstanding request has its result.
  // Step past the current edge first so a request taken on it is already counted.
  task automatic wait_drained();
    if (s_tvalid) s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Rewrite both registers while the block is idle.
  task automatic reconfigure(input int unsigned cap, input int unsigned rate);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_CAPACITY;
    cfg_wdata <= CFG_W'(cap);
    @(posedge clk);
    cfg_idx   <= CFG_DRAIN_RATE;
    cfg_wdata <= CFG_W'(rate);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_cap  = cap;
    cur_rate = rate;
  endtask

  // Arrivals scaled to the row's turnover, with idle ticks and overloads mixed in.
  function automatic int unsigned pick_arrivals();
    int unsigned span;
    int unsigned row;
    span = cur_cap * 3 + cur_rate * 2 + 8;
    if (span > 65535) span = 65535;
    row = cur_cap * NUM_BUCKETS + 1;
    if (row > 65535) row = 65535;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: return 0;
      16, 17:     return $urandom_range(0, row);
      18:         return $urandom_range(0, 65535);
      19:         return 65535;
      default:    return $urandom_range(0, span);
    endcase
  endfunction

  initial begin
    int unsigned cap;
    int unsigned rate;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: empty start, single packet, exact fill, row overflow, drain-out.
    send_tick(0);
    send_tick(1);
    send_tick(16);
    send_tick(17);
    send_tick(65535);
    send_tick(65535);
    send_tick(0);
    send_tick(0);
    send_tick(0);

    // Widest buckets with no drain: levels pile up and are kept.
    reconfigure(65535, 0);
    send_tick(65535);
    send_tick(65535);
    send_tick(1);
    send_tick(0);

    // Shrink the capacity below the held levels: those buckets count as full.
    reconfigure(8, 3);
    send_tick(5);
    send_tick(0);
    send_tick(0);

    // Zero capacity: open empty buckets up to the full row, drop everything.
    reconfigure(0, 65535);
    send_tick(100);
    send_tick(0);

    // One packet per bucket and an unlimited drain.
    reconfigure(1, 65535);
    send_tick(65535);
    send_tick(3);
    send_tick(0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0:       cap = $urandom_range(1, 8);
        1:       cap = $urandom_range(9, 64);
        2:       cap = $urandom_range(65, 4096);
        3:       cap = $urandom_range(0, 65535);
        default: cap = ($urandom_range(0, 1) == 0) ? 1 : 65535;
      endcase
      case ($urandom_range(0, 4))
        0:       rate = 0;
        1, 2:    rate = $urandom_range(1, (cap > 1) ? cap : 1);
        3:       rate = $urandom_range(0, 65535);
        default: rate = 65535;
      endcase
      reconfigure(cap, rate);
      repeat (PHASE_TICKS) begin
        send_tick(pick_arrivals());
        if ($urandom_range(0, 59) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/embs_pkg.sv
hdl/embs_ram.sv
hdl/embs_ctrl.sv
hdl/embs_dpath.sv
hdl/elastic_multi_bucket_shaper_unit.sv
tb/embs_checker.sv
tb/testbench.sv
